@@ sv/rvex_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rvex_pkg: shared types and codes of the RV32I execute unit
// Item layouts, operation codes, exception causes and memory request codes.
// ----------------------------------------------------------------------------
package rvex_pkg;

	localparam int REG_COUNT_DEF = 32;

	// Operation codes of the func field.
	localparam logic [5:0] FN_ADDI     = 6'd0;
	localparam logic [5:0] FN_ANDI     = 6'd1;
	localparam logic [5:0] FN_ORI      = 6'd2;
	localparam logic [5:0] FN_XORI     = 6'd3;
	localparam logic [5:0] FN_SLTI     = 6'd4;
	localparam logic [5:0] FN_SLTIU    = 6'd5;
	localparam logic [5:0] FN_SLLI     = 6'd6;
	localparam logic [5:0] FN_SRLI     = 6'd7;
	localparam logic [5:0] FN_SRAI     = 6'd8;
	localparam logic [5:0] FN_LUI      = 6'd9;
	localparam logic [5:0] FN_AUIPC    = 6'd10;
	localparam logic [5:0] FN_LB       = 6'd11;
	localparam logic [5:0] FN_LH       = 6'd12;
	localparam logic [5:0] FN_LW       = 6'd13;
	localparam logic [5:0] FN_LBU      = 6'd14;
	localparam logic [5:0] FN_LHU      = 6'd15;
	localparam logic [5:0] FN_SB       = 6'd16;
	localparam logic [5:0] FN_SH       = 6'd17;
	localparam logic [5:0] FN_SW       = 6'd18;
	localparam logic [5:0] FN_JAL      = 6'd19;
	localparam logic [5:0] FN_JALR     = 6'd20;
	localparam logic [5:0] FN_BEQ      = 6'd21;
	localparam logic [5:0] FN_BNE      = 6'd22;
	localparam logic [5:0] FN_BLT      = 6'd23;
	localparam logic [5:0] FN_BGE      = 6'd24;
	localparam logic [5:0] FN_BLTU     = 6'd25;
	localparam logic [5:0] FN_BGEU     = 6'd26;
	localparam logic [5:0] FN_FENCE    = 6'd27;
	localparam logic [5:0] FN_FENCE_TSO = 6'd28;
	localparam logic [5:0] FN_ECALL    = 6'd29;
	localparam logic [5:0] FN_EBREAK   = 6'd30;
	localparam logic [5:0] FN_ADD      = 6'd31;
	localparam logic [5:0] FN_SUB      = 6'd32;
	localparam logic [5:0] FN_AND      = 6'd33;
	localparam logic [5:0] FN_OR       = 6'd34;
	localparam logic [5:0] FN_XOR      = 6'd35;
	localparam logic [5:0] FN_SLT      = 6'd36;
	localparam logic [5:0] FN_SLTU     = 6'd37;
	localparam logic [5:0] FN_SLL      = 6'd38;
	localparam logic [5:0] FN_SRL      = 6'd39;
	localparam logic [5:0] FN_SRA      = 6'd40;
	localparam logic [5:0] FN_LOAD_RSP = 6'd41;

	// Exception causes.
	localparam logic [2:0] EXC_NONE     = 3'd0;
	localparam logic [2:0] EXC_ILLEGAL  = 3'd1;
	localparam logic [2:0] EXC_FETCH    = 3'd2;
	localparam logic [2:0] EXC_LOAD     = 3'd3;
	localparam logic [2:0] EXC_STORE    = 3'd4;
	localparam logic [2:0] EXC_ECALL    = 3'd5;
	localparam logic [2:0] EXC_EBREAK   = 3'd6;

	// Memory request kinds and sizes.
	localparam logic [1:0] MOP_NONE  = 2'd0;
	localparam logic [1:0] MOP_READ  = 2'd1;
	localparam logic [1:0] MOP_WRITE = 2'd2;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	typedef enum logic [2:0] {
		KIND_LB  = 3'd0,
		KIND_LH  = 3'd1,
		KIND_LW  = 3'd2,
		KIND_LBU = 3'd3,
		KIND_LHU = 3'd4
	} load_kind_t;

	typedef enum logic [1:0] {
		OPS_ZERO   = 2'd0,
		OPS_MEM    = 2'd1,
		OPS_BYPASS = 2'd2
	} opsel_t;

	typedef struct packed {
		logic [5:0]         func;
		logic [4:0]         dest_index;
		logic [4:0]         src1_index;
		logic [4:0]         src2_index;
		logic signed [31:0] immediate;
		logic [31:0]        load_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [4:0]  write_index;
		logic [31:0] write_value;
		logic [1:0]  mem_op;
		logic [31:0] mem_addr;
		logic [1:0]  mem_size;
		logic [31:0] store_data;
		logic [2:0]  exception;
	} res_t;

endpackage
`default_nettype wire

@@ sv/rv32i_execute_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_execute_unit: RV32I execute stage with register file and PC
// Accepts one decoded instruction item per cycle while the result is not stalled, and returns one result item.
// ----------------------------------------------------------------------------
// An accepted item is held in the operand register, executes from there and is
// written to the result register once that register is free.
// Throughput: one item per cycle while the result is not stalled, set by the single execute pass between the
// operand register and the result register.
// Reset: PC is zero, all registers read as zero through per-entry valid bits,
// no load is pending and both stages are empty.
module rv32i_execute_unit #(
	parameter int REG_COUNT = rvex_pkg::REG_COUNT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_write_en,
	input  wire logic [31:0]   cfg_write_data,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire rvex_pkg::cmd_t cmd_item,
	output logic               res_valid,
	input  wire logic          res_stall,
	output rvex_pkg::res_t     res_item
);

	localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	// Register file storage; entries not yet written read as zero.
	logic [31:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_valid_q;

	// Architectural state.
	logic [31:0]          pc_q;
	logic                 pend_q;
	logic [4:0]           pend_dest_q;
	rvex_pkg::load_kind_t pend_kind_q;

	// Stage 1: accepted item and its operands.
	logic             valid_s1;
	rvex_pkg::cmd_t   cmd_s1;
	logic [31:0]      a_raw_s1, b_raw_s1;
	rvex_pkg::opsel_t a_sel_s1, b_sel_s1;
	logic [31:0]      byp_val_s1;

	// Stage 2: result.
	logic             res_valid_s2;
	rvex_pkg::res_t   res_s2;

	logic s2_free, s1_adv, cmd_acc;

	assign s2_free   = !res_valid_s2 || !res_stall;
	assign s1_adv    = valid_s1 && s2_free;
	assign cmd_stall = valid_s1 && !s2_free;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_s2;
	assign res_item  = res_s2;

	// Register file write from the executing item.
	logic             wr_en;
	logic [4:0]       wr_idx;
	logic [31:0]      wr_val;

	// Read ports, checked against x0 and the implemented register count.
	logic             rs1_ok, rs2_ok;
	logic [IDX_W-1:0] rs1_addr, rs2_addr, wr_addr;

	assign rs1_ok   = (cmd_item.src1_index != 5'd0) &&
	                  ({1'b0, cmd_item.src1_index} < 6'(REG_COUNT));
	assign rs2_ok   = (cmd_item.src2_index != 5'd0) &&
	                  ({1'b0, cmd_item.src2_index} < 6'(REG_COUNT));
	assign rs1_addr = rs1_ok ? cmd_item.src1_index[IDX_W-1:0] : '0;
	assign rs2_addr = rs2_ok ? cmd_item.src2_index[IDX_W-1:0] : '0;
	assign wr_addr  = wr_idx[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_valid_q <= '0;
		end else if (wr_en) begin
			rf_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Operand capture. A write by the item executing at the same edge is
	// forwarded, since the memory read sees the old contents.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1     <= cmd_item;
			a_raw_s1   <= rf_mem[rs1_addr];
			b_raw_s1   <= rf_mem[rs2_addr];
			byp_val_s1 <= wr_val;
			if (!rs1_ok) begin
				a_sel_s1 <= rvex_pkg::OPS_ZERO;
			end else if (wr_en && wr_idx == cmd_item.src1_index) begin
				a_sel_s1 <= rvex_pkg::OPS_BYPASS;
			end else if (rf_valid_q[rs1_addr]) begin
				a_sel_s1 <= rvex_pkg::OPS_MEM;
			end else begin
				a_sel_s1 <= rvex_pkg::OPS_ZERO;
			end
			if (!rs2_ok) begin
				b_sel_s1 <= rvex_pkg::OPS_ZERO;
			end else if (wr_en && wr_idx == cmd_item.src2_index) begin
				b_sel_s1 <= rvex_pkg::OPS_BYPASS;
			end else if (rf_valid_q[rs2_addr]) begin
				b_sel_s1 <= rvex_pkg::OPS_MEM;
			end else begin
				b_sel_s1 <= rvex_pkg::OPS_ZERO;
			end
		end
	end

	logic [31:0] op_a, op_b;

	always_comb begin
		case (a_sel_s1)
			rvex_pkg::OPS_MEM:    op_a = a_raw_s1;
			rvex_pkg::OPS_BYPASS: op_a = byp_val_s1;
			default:              op_a = '0;
		endcase
		case (b_sel_s1)
			rvex_pkg::OPS_MEM:    op_b = b_raw_s1;
			rvex_pkg::OPS_BYPASS: op_b = byp_val_s1;
			default:              op_b = '0;
		endcase
	end

	// Execute.
	logic [31:0] imm_u, a_imm, pc_imm, pc_plus4, jalr_tgt, ld;
	logic [4:0]  sh_i, sh_r;

	assign imm_u    = cmd_s1.immediate;
	assign a_imm    = op_a + imm_u;
	assign pc_imm   = pc_q + imm_u;
	assign pc_plus4 = pc_q + 32'd4;
	assign jalr_tgt = {a_imm[31:1], 1'b0};
	assign ld       = cmd_s1.load_data;
	assign sh_i     = imm_u[4:0];
	assign sh_r     = op_b[4:0];

	logic [31:0]    ex_val, npc, maddr, sdata;
	logic           has_wr, taken, is_branch, pend_set, pend_clr, wr_ok;
	logic [4:0]     ex_rd;
	logic [2:0]     exc;
	logic [1:0]     mop, msize;
	rvex_pkg::res_t res_d;

	always_comb begin
		ex_val   = '0;
		npc      = pc_plus4;
		maddr    = '0;
		sdata    = '0;
		has_wr   = 1'b0;
		taken    = 1'b0;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		ex_rd    = cmd_s1.dest_index;
		exc      = rvex_pkg::EXC_NONE;
		mop      = rvex_pkg::MOP_NONE;
		msize    = rvex_pkg::SZ_BYTE;

		case (cmd_s1.func)
			rvex_pkg::FN_ADDI:  begin ex_val = a_imm;         has_wr = 1'b1; end
			rvex_pkg::FN_ANDI:  begin ex_val = op_a & imm_u;  has_wr = 1'b1; end
			rvex_pkg::FN_ORI:   begin ex_val = op_a | imm_u;  has_wr = 1'b1; end
			rvex_pkg::FN_XORI:  begin ex_val = op_a ^ imm_u;  has_wr = 1'b1; end
			rvex_pkg::FN_SLTI: begin
				ex_val = {31'd0, $signed(op_a) < $signed(imm_u)};
				has_wr = 1'b1;
			end
			rvex_pkg::FN_SLTIU: begin
				ex_val = {31'd0, op_a < imm_u};
				has_wr = 1'b1;
			end
			rvex_pkg::FN_SLLI:  begin ex_val = op_a << sh_i;  has_wr = 1'b1; end
			rvex_pkg::FN_SRLI:  begin ex_val = op_a >> sh_i;  has_wr = 1'b1; end
			rvex_pkg::FN_SRAI: begin
				ex_val = 32'($signed(op_a) >>> sh_i);
				has_wr = 1'b1;
			end
			rvex_pkg::FN_LUI:   begin ex_val = imm_u << 12;   has_wr = 1'b1; end
			rvex_pkg::FN_AUIPC: begin
				ex_val = pc_q + (imm_u << 12);
				has_wr = 1'b1;
			end
			rvex_pkg::FN_LB, rvex_pkg::FN_LH, rvex_pkg::FN_LW,
			rvex_pkg::FN_LBU, rvex_pkg::FN_LHU: begin
				if (cmd_s1.func == rvex_pkg::FN_LW) begin
					msize = rvex_pkg::SZ_WORD;
				end else if (cmd_s1.func == rvex_pkg::FN_LH ||
				             cmd_s1.func == rvex_pkg::FN_LHU) begin
					msize = rvex_pkg::SZ_HALF;
				end else begin
					msize = rvex_pkg::SZ_BYTE;
				end
				if ((msize == rvex_pkg::SZ_HALF && a_imm[0]) ||
				    (msize == rvex_pkg::SZ_WORD && a_imm[1:0] != 2'd0)) begin
					exc = rvex_pkg::EXC_LOAD;
				end else begin
					mop      = rvex_pkg::MOP_READ;
					maddr    = a_imm;
					pend_set = 1'b1;
				end
			end
			rvex_pkg::FN_SB, rvex_pkg::FN_SH, rvex_pkg::FN_SW: begin
				msize = 2'(cmd_s1.func - rvex_pkg::FN_SB);
				if ((msize == rvex_pkg::SZ_HALF && a_imm[0]) ||
				    (msize == rvex_pkg::SZ_WORD && a_imm[1:0] != 2'd0)) begin
					exc = rvex_pkg::EXC_STORE;
				end else begin
					mop   = rvex_pkg::MOP_WRITE;
					maddr = a_imm;
					sdata = op_b;
				end
			end
			rvex_pkg::FN_JAL: begin
				if (pc_imm[1:0] != 2'd0) begin
					exc = rvex_pkg::EXC_FETCH;
				end else begin
					ex_val = pc_plus4;
					has_wr = 1'b1;
					npc    = pc_imm;
				end
			end
			rvex_pkg::FN_JALR: begin
				if (jalr_tgt[1:0] != 2'd0) begin
					exc = rvex_pkg::EXC_FETCH;
				end else begin
					ex_val = pc_plus4;
					has_wr = 1'b1;
					npc    = jalr_tgt;
				end
			end
			rvex_pkg::FN_BEQ:  taken = (op_a == op_b);
			rvex_pkg::FN_BNE:  taken = (op_a != op_b);
			rvex_pkg::FN_BLT:  taken = ($signed(op_a) < $signed(op_b));
			rvex_pkg::FN_BGE:  taken = !($signed(op_a) < $signed(op_b));
			rvex_pkg::FN_BLTU: taken = (op_a < op_b);
			rvex_pkg::FN_BGEU: taken = (op_a >= op_b);
			rvex_pkg::FN_FENCE, rvex_pkg::FN_FENCE_TSO: ;
			rvex_pkg::FN_ECALL:  exc = rvex_pkg::EXC_ECALL;
			rvex_pkg::FN_EBREAK: exc = rvex_pkg::EXC_EBREAK;
			rvex_pkg::FN_ADD:  begin ex_val = op_a + op_b;  has_wr = 1'b1; end
			rvex_pkg::FN_SUB:  begin ex_val = op_a - op_b;  has_wr = 1'b1; end
			rvex_pkg::FN_AND:  begin ex_val = op_a & op_b;  has_wr = 1'b1; end
			rvex_pkg::FN_OR:   begin ex_val = op_a | op_b;  has_wr = 1'b1; end
			rvex_pkg::FN_XOR:  begin ex_val = op_a ^ op_b;  has_wr = 1'b1; end
			rvex_pkg::FN_SLT: begin
				ex_val = {31'd0, $signed(op_a) < $signed(op_b)};
				has_wr = 1'b1;
			end
			rvex_pkg::FN_SLTU: begin
				ex_val = {31'd0, op_a < op_b};
				has_wr = 1'b1;
			end
			rvex_pkg::FN_SLL:  begin ex_val = op_a << sh_r; has_wr = 1'b1; end
			rvex_pkg::FN_SRL:  begin ex_val = op_a >> sh_r; has_wr = 1'b1; end
			rvex_pkg::FN_SRA: begin
				ex_val = 32'($signed(op_a) >>> sh_r);
				has_wr = 1'b1;
			end
			rvex_pkg::FN_LOAD_RSP: begin
				// A response with no load outstanding changes nothing.
				npc = pc_q;
				if (pend_q) begin
					pend_clr = 1'b1;
					has_wr   = 1'b1;
					ex_rd    = pend_dest_q;
					case (pend_kind_q)
						rvex_pkg::KIND_LB:  ex_val = {{24{ld[7]}}, ld[7:0]};
						rvex_pkg::KIND_LH:  ex_val = {{16{ld[15]}}, ld[15:0]};
						rvex_pkg::KIND_LBU: ex_val = {24'd0, ld[7:0]};
						rvex_pkg::KIND_LHU: ex_val = {16'd0, ld[15:0]};
						default:            ex_val = ld;
					endcase
				end
			end
			default: exc = rvex_pkg::EXC_ILLEGAL;
		endcase

		is_branch = (cmd_s1.func >= rvex_pkg::FN_BEQ) &&
		            (cmd_s1.func <= rvex_pkg::FN_BGEU);
		if (is_branch && taken) begin
			if (pc_imm[1:0] != 2'd0) begin
				exc = rvex_pkg::EXC_FETCH;
			end else begin
				npc = pc_imm;
			end
		end

		wr_ok = has_wr && (exc == rvex_pkg::EXC_NONE) && (ex_rd != 5'd0) &&
		        ({1'b0, ex_rd} < 6'(REG_COUNT));

		res_d = '0;
		if (exc != rvex_pkg::EXC_NONE) begin
			res_d.next_pc   = pc_q;
			res_d.exception = exc;
		end else begin
			res_d.next_pc     = npc;
			res_d.reg_write   = wr_ok;
			res_d.write_index = wr_ok ? ex_rd : 5'd0;
			res_d.write_value = wr_ok ? ex_val : 32'd0;
			res_d.mem_op      = mop;
			res_d.mem_addr    = maddr;
			res_d.mem_size    = (mop != rvex_pkg::MOP_NONE) ? msize : rvex_pkg::SZ_BYTE;
			res_d.store_data  = sdata;
		end
	end

	assign wr_en  = s1_adv && wr_ok;
	assign wr_idx = ex_rd;
	assign wr_val = ex_val;

	// Program counter and pending load record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			pend_q      <= 1'b0;
			pend_dest_q <= '0;
			pend_kind_q <= rvex_pkg::KIND_LB;
		end else if (cfg_write_en) begin
			pc_q <= cfg_write_data;
		end else if (s1_adv && exc == rvex_pkg::EXC_NONE) begin
			pc_q <= npc;
			if (pend_set) begin
				pend_q      <= 1'b1;
				pend_dest_q <= cmd_s1.dest_index;
				pend_kind_q <= rvex_pkg::load_kind_t'(3'(cmd_s1.func - rvex_pkg::FN_LB));
			end else if (pend_clr) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (cmd_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				res_valid_s2 <= 1'b1;
			end else if (s2_free) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res_d;
		end
	end

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RV32I execute unit
// Drives decoded instruction items with random gaps and checks every result
// item against a behavioral copy of the register file, PC and load tracker.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NREGS = rvex_pkg::REG_COUNT_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [5:0] FN_ILLEGAL_LO = rvex_pkg::FN_LOAD_RSP + 6'd1;
	localparam logic [5:0] FN_ILLEGAL_HI = 6'd63;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_write_en = 1'b0;
	logic [31:0]    cfg_write_data = '0;
	logic           cmd_valid = 1'b0;
	logic           cmd_stall;
	rvex_pkg::cmd_t cmd_item = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	rvex_pkg::res_t res_item;

	// Behavioral state of the core.
	logic [31:0]          rf [NREGS] = '{default: '0};
	logic [31:0]          cur_pc = '0;
	logic                 ld_pend = 1'b0;
	logic [4:0]           ld_dest = '0;
	rvex_pkg::load_kind_t ld_kind = rvex_pkg::KIND_LB;

	rvex_pkg::cmd_t instr_q [$];
	rvex_pkg::res_t retire_q [$];
	logic cmd_taken = 1'b0;
	logic calm = 1'b0;
	int   mismatch_count = 0;
	int   cycles = 0;

	rv32i_execute_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd_item      (cmd_item),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_item      (res_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] rf_read(logic [4:0] idx);
		if (idx == 0 || idx >= NREGS) begin
			return '0;
		end
		return rf[idx];
	endfunction

	function automatic logic rf_write(logic [4:0] idx, logic [31:0] v);
		if (idx == 0 || idx >= NREGS) begin
			return 1'b0;
		end
		rf[idx] = v;
		return 1'b1;
	endfunction

	// Executes one instruction on the behavioral state and returns its result.
	function automatic rvex_pkg::res_t predict_retire(rvex_pkg::cmd_t c);
		rvex_pkg::res_t       r;
		logic [31:0]          a, b, imm, ld, pc, npc, val, addr, maddr, sdata;
		logic [2:0]           exc;
		logic [1:0]           mop, msz;
		logic                 wr, taken;
		rvex_pkg::load_kind_t kind;
		r = '0;
		a = rf_read(c.src1_index);
		b = rf_read(c.src2_index);
		imm = c.immediate;
		ld = c.load_data;
		pc = cur_pc;
		npc = pc + 32'd4;
		exc = rvex_pkg::EXC_NONE;
		mop = rvex_pkg::MOP_NONE;
		msz = rvex_pkg::SZ_BYTE;
		maddr = '0;
		sdata = '0;
		val = '0;
		addr = '0;
		wr = 1'b0;
		taken = 1'b0;
		kind = rvex_pkg::KIND_LB;

		if (c.func == rvex_pkg::FN_LOAD_RSP) begin
			if (ld_pend) begin
				case (ld_kind)
					rvex_pkg::KIND_LB:  val = {{24{ld[7]}}, ld[7:0]};
					rvex_pkg::KIND_LH:  val = {{16{ld[15]}}, ld[15:0]};
					rvex_pkg::KIND_LBU: val = {24'd0, ld[7:0]};
					rvex_pkg::KIND_LHU: val = {16'd0, ld[15:0]};
					default:            val = ld;
				endcase
				if (rf_write(ld_dest, val)) begin
					r.reg_write = 1'b1;
					r.write_index = ld_dest;
					r.write_value = val;
				end
				ld_pend = 1'b0;
			end
			r.next_pc = pc;
			return r;
		end

		case (c.func)
			rvex_pkg::FN_ADDI:  begin val = a + imm; wr = 1'b1; end
			rvex_pkg::FN_ANDI:  begin val = a & imm; wr = 1'b1; end
			rvex_pkg::FN_ORI:   begin val = a | imm; wr = 1'b1; end
			rvex_pkg::FN_XORI:  begin val = a ^ imm; wr = 1'b1; end
			rvex_pkg::FN_SLTI:  begin val = {31'd0, $signed(a) < $signed(imm)}; wr = 1'b1; end
			rvex_pkg::FN_SLTIU: begin val = {31'd0, a < imm}; wr = 1'b1; end
			rvex_pkg::FN_SLLI:  begin val = a << imm[4:0]; wr = 1'b1; end
			rvex_pkg::FN_SRLI:  begin val = a >> imm[4:0]; wr = 1'b1; end
			rvex_pkg::FN_SRAI:  begin val = $signed(a) >>> imm[4:0]; wr = 1'b1; end
			rvex_pkg::FN_LUI:   begin val = imm << 12; wr = 1'b1; end
			rvex_pkg::FN_AUIPC: begin val = pc + (imm << 12); wr = 1'b1; end
			rvex_pkg::FN_LB, rvex_pkg::FN_LH, rvex_pkg::FN_LW,
			rvex_pkg::FN_LBU, rvex_pkg::FN_LHU: begin
				addr = a + imm;
				case (c.func)
					rvex_pkg::FN_LB: begin
						msz = rvex_pkg::SZ_BYTE;
						kind = rvex_pkg::KIND_LB;
					end
					rvex_pkg::FN_LH: begin
						msz = rvex_pkg::SZ_HALF;
						kind = rvex_pkg::KIND_LH;
					end
					rvex_pkg::FN_LW: begin
						msz = rvex_pkg::SZ_WORD;
						kind = rvex_pkg::KIND_LW;
					end
					rvex_pkg::FN_LBU: begin
						msz = rvex_pkg::SZ_BYTE;
						kind = rvex_pkg::KIND_LBU;
					end
					default: begin
						msz = rvex_pkg::SZ_HALF;
						kind = rvex_pkg::KIND_LHU;
					end
				endcase
				if ((msz == rvex_pkg::SZ_HALF && addr[0]) ||
				    (msz == rvex_pkg::SZ_WORD && addr[1:0] != 2'b00)) begin
					exc = rvex_pkg::EXC_LOAD;
				end else begin
					mop = rvex_pkg::MOP_READ;
					maddr = addr;
					ld_pend = 1'b1;
					ld_dest = c.dest_index;
					ld_kind = kind;
				end
			end
			rvex_pkg::FN_SB, rvex_pkg::FN_SH, rvex_pkg::FN_SW: begin
				addr = a + imm;
				if (c.func == rvex_pkg::FN_SB) begin
					msz = rvex_pkg::SZ_BYTE;
				end else if (c.func == rvex_pkg::FN_SH) begin
					msz = rvex_pkg::SZ_HALF;
				end else begin
					msz = rvex_pkg::SZ_WORD;
				end
				if ((msz == rvex_pkg::SZ_HALF && addr[0]) ||
				    (msz == rvex_pkg::SZ_WORD && addr[1:0] != 2'b00)) begin
					exc = rvex_pkg::EXC_STORE;
				end else begin
					mop = rvex_pkg::MOP_WRITE;
					maddr = addr;
					sdata = b;
				end
			end
			rvex_pkg::FN_JAL, rvex_pkg::FN_JALR: begin
				addr = (c.func == rvex_pkg::FN_JAL) ? (pc + imm) : ((a + imm) & ~32'h1);
				if (addr[1:0] != 2'b00) begin
					exc = rvex_pkg::EXC_FETCH;
				end else begin
					val = npc;
					wr = 1'b1;
					npc = addr;
				end
			end
			rvex_pkg::FN_BEQ:  taken = (a == b);
			rvex_pkg::FN_BNE:  taken = (a != b);
			rvex_pkg::FN_BLT:  taken = $signed(a) < $signed(b);
			rvex_pkg::FN_BGE:  taken = $signed(a) >= $signed(b);
			rvex_pkg::FN_BLTU: taken = (a < b);
			rvex_pkg::FN_BGEU: taken = (a >= b);
			rvex_pkg::FN_FENCE, rvex_pkg::FN_FENCE_TSO: ;
			rvex_pkg::FN_ECALL:  exc = rvex_pkg::EXC_ECALL;
			rvex_pkg::FN_EBREAK: exc = rvex_pkg::EXC_EBREAK;
			rvex_pkg::FN_ADD:  begin val = a + b; wr = 1'b1; end
			rvex_pkg::FN_SUB:  begin val = a - b; wr = 1'b1; end
			rvex_pkg::FN_AND:  begin val = a & b; wr = 1'b1; end
			rvex_pkg::FN_OR:   begin val = a | b; wr = 1'b1; end
			rvex_pkg::FN_XOR:  begin val = a ^ b; wr = 1'b1; end
			rvex_pkg::FN_SLT:  begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
			rvex_pkg::FN_SLTU: begin val = {31'd0, a < b}; wr = 1'b1; end
			rvex_pkg::FN_SLL:  begin val = a << b[4:0]; wr = 1'b1; end
			rvex_pkg::FN_SRL:  begin val = a >> b[4:0]; wr = 1'b1; end
			rvex_pkg::FN_SRA:  begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
			default: exc = rvex_pkg::EXC_ILLEGAL;
		endcase

		// Among branches, only a taken one checks its target alignment.
		if (c.func >= rvex_pkg::FN_BEQ && c.func <= rvex_pkg::FN_BGEU && taken) begin
			addr = pc + imm;
			if (addr[1:0] != 2'b00) begin
				exc = rvex_pkg::EXC_FETCH;
			end else begin
				npc = addr;
			end
		end

		if (exc != rvex_pkg::EXC_NONE) begin
			r.next_pc = pc;
			r.exception = exc;
			return r;
		end

		if (wr && rf_write(c.dest_index, val)) begin
			r.reg_write = 1'b1;
			r.write_index = c.dest_index;
			r.write_value = val;
		end
		cur_pc = npc;
		r.next_pc = npc;
		r.mem_op = mop;
		r.mem_addr = maddr;
		r.mem_size = (mop != rvex_pkg::MOP_NONE) ? msz : rvex_pkg::SZ_BYTE;
		r.store_data = sdata;
		return r;
	endfunction

	function automatic rvex_pkg::cmd_t mk(logic [5:0] fn, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm, logic [31:0] ld);
		rvex_pkg::cmd_t c;
		c.func = fn;
		c.dest_index = rd;
		c.src1_index = rs1;
		c.src2_index = rs2;
		c.immediate = imm;
		c.load_data = ld;
		return c;
	endfunction

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(6))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			4, 5: return $urandom_range(4095) - 2048;
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(rvex_pkg::res_t e, rvex_pkg::res_t g);
		check_field("next_pc", e.next_pc, g.next_pc);
		check_field("reg_write", 32'(e.reg_write), 32'(g.reg_write));
		check_field("write_index", 32'(e.write_index), 32'(g.write_index));
		check_field("write_value", e.write_value, g.write_value);
		check_field("mem_op", 32'(e.mem_op), 32'(g.mem_op));
		check_field("mem_addr", e.mem_addr, g.mem_addr);
		check_field("mem_size", 32'(e.mem_size), 32'(g.mem_size));
		check_field("store_data", e.store_data, g.store_data);
		check_field("exception", 32'(e.exception), 32'(g.exception));
	endtask

	// Random program: mostly legal instructions, loads answered a few items
	// later, plus stray load responses and illegal codes as noise.
	task automatic gen_program(int count);
		int          made;
		int          ld_gap;
		int          pick;
		logic        ld_out;
		logic [5:0]  fn;
		logic [4:0]  rs1;
		logic [31:0] imm;
		made = 0;
		ld_gap = 0;
		ld_out = 1'b0;
		while (made < count) begin
			if (ld_out && ld_gap == 0) begin
				instr_q.push_back(mk(rvex_pkg::FN_LOAD_RSP, 5'($urandom), 5'($urandom),
					5'($urandom), $urandom, $urandom));
				ld_out = 1'b0;
			end else begin
				pick = $urandom_range(99);
				rs1 = 5'($urandom);
				imm = rand_imm();
				if (ld_gap > 0) begin
					ld_gap--;
				end
				if (pick < 3) begin
					fn = rvex_pkg::FN_LOAD_RSP;
				end else if (pick < 6) begin
					fn = 6'($urandom_range(32'(FN_ILLEGAL_LO), 32'(FN_ILLEGAL_HI)));
				end else if (pick < 22) begin
					fn = 6'($urandom_range(32'(rvex_pkg::FN_LB), 32'(rvex_pkg::FN_SW)));
				end else begin
					fn = 6'($urandom_range(32'(rvex_pkg::FN_ADDI), 32'(rvex_pkg::FN_SRA)));
				end
				if (fn >= rvex_pkg::FN_LB && fn <= rvex_pkg::FN_SW &&
				    $urandom_range(1) == 0) begin
					rs1 = '0;
					imm[1:0] = 2'b00;
				end
				if (fn >= rvex_pkg::FN_JAL && fn <= rvex_pkg::FN_BGEU &&
				    $urandom_range(99) < 85) begin
					imm[1:0] = 2'b00;
					if (fn == rvex_pkg::FN_JALR) begin
						rs1 = '0;
					end
				end
				if (fn >= rvex_pkg::FN_LB && fn <= rvex_pkg::FN_LHU) begin
					ld_out = 1'b1;
					ld_gap = $urandom_range(3);
				end
				instr_q.push_back(mk(fn, 5'($urandom), rs1, 5'($urandom), imm, $urandom));
				if (fn != rvex_pkg::FN_LOAD_RSP) begin
					made++;
				end
			end
		end
	endtask

	task automatic drain();
		while (instr_q.size() != 0 || cmd_valid || retire_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// The configuration write loads the program counter directly.
	task automatic write_reset_pc(logic [31:0] v);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cur_pc = v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Driver: a new item goes out only once the current one has been taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd_valid || cmd_taken) begin
				cmd_taken = 1'b0;
				if (instr_q.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
					cmd_item <= instr_q.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			res_stall <= !calm && ($urandom_range(99) < 14);
		end
	end

	// Monitor: predict on acceptance, check each result in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				cmd_taken = 1'b1;
				retire_q.push_back(predict_retire(cmd_item));
			end
			if (res_valid && !res_stall) begin
				if (retire_q.size() == 0) begin
					$error("result item with no instruction outstanding");
					mismatch_count++;
				end else begin
					check_result(retire_q.pop_front(), res_item);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_reset_pc(32'h0);

		instr_q.push_back(mk(rvex_pkg::FN_ADDI, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LUI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, '0));
		instr_q.push_back(mk(rvex_pkg::FN_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF, '0));
		instr_q.push_back(mk(rvex_pkg::FN_SRAI, 5'd4, 5'd1, 5'd0, 32'h0000_003F, '0));
		instr_q.push_back(mk(rvex_pkg::FN_SLL, 5'd5, 5'd3, 5'd1, '0, '0));
		instr_q.push_back(mk(rvex_pkg::FN_SLT, 5'd6, 5'd1, 5'd3, '0, '0));
		instr_q.push_back(mk(rvex_pkg::FN_SLTU, 5'd7, 5'd1, 5'd3, '0, '0));
		// A write to x0 is discarded.
		instr_q.push_back(mk(rvex_pkg::FN_ADD, 5'd0, 5'd1, 5'd3, '0, '0));
		instr_q.push_back(mk(rvex_pkg::FN_BEQ, 5'd0, 5'd1, 5'd1, 32'd8, '0));
		instr_q.push_back(mk(rvex_pkg::FN_BNE, 5'd0, 5'd1, 5'd3, 32'd6, '0));
		// Not taken, so the misaligned offset must not raise.
		instr_q.push_back(mk(rvex_pkg::FN_BLT, 5'd0, 5'd3, 5'd1, 32'd2, '0));
		instr_q.push_back(mk(rvex_pkg::FN_JAL, 5'd9, 5'd0, 5'd0, 32'hFFFF_FFFC, '0));
		instr_q.push_back(mk(rvex_pkg::FN_JALR, 5'd10, 5'd0, 5'd0, 32'd13, '0));
		instr_q.push_back(mk(rvex_pkg::FN_JALR, 5'd10, 5'd0, 5'd0, 32'd2, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LOAD_RSP, 5'd11, 5'd0, 5'd0, '0, 32'hDEAD_BEEF));
		instr_q.push_back(mk(rvex_pkg::FN_LW, 5'd11, 5'd0, 5'd0, 32'd2, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LH, 5'd11, 5'd0, 5'd0, 32'd1, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LH, 5'd11, 5'd0, 5'd0, 32'd6, '0));
		instr_q.push_back(mk(rvex_pkg::FN_SW, 5'd0, 5'd0, 5'd1, 32'h100, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LOAD_RSP, 5'd0, 5'd0, 5'd0, '0, 32'h1234_8001));
		instr_q.push_back(mk(rvex_pkg::FN_SH, 5'd0, 5'd0, 5'd1, 32'd3, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LBU, 5'd12, 5'd0, 5'd0, 32'hFFFF_FFFF, '0));
		instr_q.push_back(mk(rvex_pkg::FN_LOAD_RSP, 5'd0, 5'd0, 5'd0, '0, 32'hFFFF_FFFF));
		instr_q.push_back(mk(rvex_pkg::FN_AUIPC, 5'd13, 5'd0, 5'd0, 32'h0008_0000, '0));
		instr_q.push_back(mk(rvex_pkg::FN_ECALL, 5'd0, 5'd0, 5'd0, '0, '0));
		instr_q.push_back(mk(rvex_pkg::FN_EBREAK, 5'd0, 5'd0, 5'd0, '0, '0));
		instr_q.push_back(mk(FN_ILLEGAL_HI, 5'd14, 5'd1, 5'd1, '0, '0));
		drain();

		calm = 1'b1;
		write_reset_pc(32'hFFFF_FFFC);
		gen_program(350);
		drain();
		calm = 1'b0;

		write_reset_pc(32'hFFFF_FFFF);
		gen_program(250);
		drain();

		write_reset_pc($urandom & ~32'h3);
		gen_program(350);
		drain();

		write_reset_pc(32'h0000_1000);
		gen_program(350);
		drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
